// ----- hw/rtl/vnaa_pkg.sv -----
// ----------------------------------------------------------------------------
// vnaa_pkg
// Shared types for the nearest actor assignment core: item codes, the
// broadcast item, the link handed along the cell chain and the result.
// ----------------------------------------------------------------------------
package vnaa_pkg;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_LOAD     = 2'd1,
        ACT_OPEN     = 2'd2,
        ACT_CLASSIFY = 2'd3
    } action_t;

    // Item held stable and broadcast to every cell while it walks the chain
    typedef struct packed {
        action_t            op;
        logic [3:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] box_x_high;
        logic signed [15:0] box_y_high;
        logic [14:0]        reach;
    } item_t;

    // Running summary passed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        any;
        logic        found;
        logic [4:0]  added;
        logic [3:0]  index;
        logic [32:0] best;
        logic [29:0] reach_sq;
    } link_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic       has_actor;
        logic [3:0] actor_index;
        logic       voxel_kept;
        logic [4:0] members_added;
    } result_t;

endpackage

// ----- hw/rtl/voxel_nearest_actor_assign_core.sv -----
// ----------------------------------------------------------------------------
// voxel_nearest_actor_assign_core
// Nearest actor assignment of voxels with a reach gate, over a cell chain.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An accepted item is latched and broadcast
// to a chain of MAX_ACTORS cells, one per actor slot; a token then walks the
// chain one cell per cycle. result_valid rises after the go and launch
// registers (which let the cell squares settle), one register per cell and
// the output register, and item_stall drops in that same cycle unless the
// result has to wait behind another. A result waiting on a stalled output
// sits in a two-entry output buffer and does not block the next item, but a
// second finished result does.
// Actor slots at or above 16 cannot be loaded and never take part.
module voxel_nearest_actor_assign_core #(
    parameter int MAX_ACTORS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  slot,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] box_x_high,
    input  logic signed [15:0] box_y_high,
    input  logic [14:0] reach,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  item_kind,
    output logic        has_actor,
    output logic [3:0]  actor_index,
    output logic        voxel_kept,
    output logic [4:0]  members_added
);

    vnaa_pkg::item_t   item_reg;
    vnaa_pkg::link_t   head;
    vnaa_pkg::link_t   chain [0:MAX_ACTORS];
    vnaa_pkg::link_t   tail;
    vnaa_pkg::result_t res;
    vnaa_pkg::result_t out_reg;
    vnaa_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic              go_reg;
    logic              launch_reg;
    logic              busy_reg;
    logic              accept;
    logic              done;
    logic              out_free;

    assign item_stall = busy_reg || skid_valid_reg;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op         <= vnaa_pkg::action_t'(action);
            item_reg.slot       <= slot;
            item_reg.pos_x      <= pos_x;
            item_reg.pos_y      <= pos_y;
            item_reg.box_x_high <= box_x_high;
            item_reg.box_y_high <= box_y_high;
            item_reg.reach      <= reach;
        end
    end

    // go_reg delays the launch so the cell squares settle before the token starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg     <= 1'b0;
            launch_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            go_reg     <= accept;
            launch_reg <= go_reg;
            if (accept)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
        end
    end

    always_comb
    begin
        head       = '0;
        head.valid = launch_reg;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < MAX_ACTORS; i++)
    begin : g_cell
        vnaa_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .item     (item_reg),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    assign tail = chain[MAX_ACTORS];
    assign done = tail.valid;

    always_comb
    begin
        res.item_kind     = item_reg.op;
        res.has_actor     = tail.any;
        res.actor_index   = tail.index;
        res.voxel_kept    = tail.found && (tail.best < 33'(tail.reach_sq));
        res.members_added = tail.added;
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = done;
            end
            else
                out_valid_next = done;
        end
        else if (done)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (done)
                    skid_reg <= res;
            end
            else if (done)
                out_reg <= res;
        end
        else if (done)
            skid_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign item_kind     = out_reg.item_kind;
    assign has_actor     = out_reg.has_actor;
    assign actor_index   = out_reg.actor_index;
    assign voxel_kept    = out_reg.voxel_kept;
    assign members_added = out_reg.members_added;

endmodule

// ----- hw/rtl/vnaa_cell.sv -----
// ----------------------------------------------------------------------------
// vnaa_cell
// One actor slot. Holds position, squared reach and flags; when the token
// passes it applies the item to its own slot and updates the running summary.
// ----------------------------------------------------------------------------
module vnaa_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  vnaa_pkg::item_t item,
    input  vnaa_pkg::link_t link_in,
    output vnaa_pkg::link_t link_out
);

    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [29:0]        rsq_reg;
    logic [29:0]        rsq_next;
    logic [31:0]        sqx_reg;
    logic [31:0]        sqy_reg;
    logic               valid_reg;
    logic               valid_next;
    logic               taken_reg;
    logic               taken_next;
    logic               member_reg;
    logic               member_next;
    vnaa_pkg::link_t    link_reg;
    vnaa_pkg::link_t    link_next;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [32:0]        dist_sum;
    logic               slot_hit;
    logic               in_box;
    logic               load_here;

    assign dx    = $signed({item.pos_x[15], item.pos_x}) - $signed({x_reg[15], x_reg});
    assign dy    = $signed({item.pos_y[15], item.pos_y}) - $signed({y_reg[15], y_reg});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    // squares follow the held item; they settle before the token arrives
    always_ff @(posedge clk)
    begin
        sqx_reg <= dx_sq[31:0];
        sqy_reg <= dy_sq[31:0];
    end

    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign slot_hit = (int'(item.slot) == IDX);
    assign in_box   = (x_reg >= item.pos_x) && (x_reg <= item.box_x_high) &&
                      (y_reg >= item.pos_y) && (y_reg <= item.box_y_high);
    assign rsq_next = 30'(item.reach) * 30'(item.reach);
    assign load_here = link_in.valid && (item.op == vnaa_pkg::ACT_LOAD) && slot_hit;

    always_comb
    begin
        valid_next  = valid_reg;
        taken_next  = taken_reg;
        member_next = member_reg;
        link_next   = link_in;
        if (link_in.valid)
        begin
            unique case (item.op)
                vnaa_pkg::ACT_START:
                begin
                    valid_next  = 1'b0;
                    taken_next  = 1'b0;
                    member_next = 1'b0;
                end
                vnaa_pkg::ACT_LOAD:
                begin
                    if (slot_hit)
                    begin
                        valid_next  = 1'b1;
                        taken_next  = 1'b0;
                        member_next = 1'b0;
                    end
                end
                vnaa_pkg::ACT_OPEN:
                begin
                    // first volume wins: a taken actor stays out
                    member_next = valid_reg && !taken_reg && in_box;
                    if (member_next)
                    begin
                        taken_next      = 1'b1;
                        link_next.added = link_in.added + 5'd1;
                    end
                end
                vnaa_pkg::ACT_CLASSIFY:
                begin
                    // strict less-than keeps the lowest slot on a tie
                    if (member_reg && (!link_in.found || dist_sum < link_in.best))
                    begin
                        link_next.found    = 1'b1;
                        link_next.index    = 4'(IDX);
                        link_next.best     = dist_sum;
                        link_next.reach_sq = rsq_reg;
                    end
                end
            endcase
        end
        link_next.any = link_in.any | member_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            x_reg   <= item.pos_x;
            y_reg   <= item.pos_y;
            rsq_reg <= rsq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            taken_reg  <= 1'b0;
            member_reg <= 1'b0;
            link_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            taken_reg  <= taken_next;
            member_reg <= member_next;
            link_reg   <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ----- hw/rtl/vnaa_checker.sv -----
// ----------------------------------------------------------------------------
// vnaa_checker
// Port-level checks for the nearest actor assignment core, bound to the top.
// ----------------------------------------------------------------------------
module vnaa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  item_kind,
    input logic        has_actor,
    input logic [3:0]  actor_index,
    input logic        voxel_kept,
    input logic [4:0]  members_added
);

    // one item in flight: a transfer closes the input until its result is out
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input open right after a transfer");

    a_classify_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (item_kind != vnaa_pkg::ACT_CLASSIFY) |->
            (actor_index == 4'd0) && !voxel_kept)
        else $error("voxel fields set on a non-classify result");

    a_open_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (item_kind != vnaa_pkg::ACT_OPEN) |-> (members_added == 5'd0))
        else $error("members added on a non-open result");

    a_kept_needs_actor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && voxel_kept |-> has_actor)
        else $error("voxel kept with no member actor");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(item_kind) &&
            $stable(actor_index) && $stable(voxel_kept) && $stable(members_added))
        else $error("stalled result changed");

endmodule

bind voxel_nearest_actor_assign_core vnaa_checker u_vnaa_checker (.*);

// ----- tb/voxel_nearest_actor_assign_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_nearest_actor_assign_core_tb
// Self-checking bench for the nearest actor assignment core. A scoreboard
// keeps its own actor table, predicts one result per accepted item and checks
// the results in order. Directed items cover table extremes, ties, inverted
// boxes and reach limits; random frames load actors, open volumes and
// classify voxels under random idling on both sides.
// ----------------------------------------------------------------------------
module voxel_nearest_actor_assign_core_tb;

    localparam int TABLE_SLOTS     = 16;
    localparam int LATENCY         = TABLE_SLOTS + 3;
    localparam int TOTAL_ITEMS     = 580;
    localparam int IDLE_PCT        = 29;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_CYCLES = 3000;

    localparam logic signed [15:0] C_MIN = 16'sh8000;
    localparam logic signed [15:0] C_MAX = 16'sh7FFF;
    localparam logic [14:0]        R_MAX = 15'h7FFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [1:0]          action = '0;
    logic [3:0]          slot = '0;
    logic signed [15:0]  pos_x = '0;
    logic signed [15:0]  pos_y = '0;
    logic signed [15:0]  box_x_high = '0;
    logic signed [15:0]  box_y_high = '0;
    logic [14:0]         reach = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [1:0]          item_kind;
    logic                has_actor;
    logic [3:0]          actor_index;
    logic                voxel_kept;
    logic [4:0]          members_added;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // Actor table model and the queue of results still owed by the core
    class assign_scoreboard;
        logic signed [15:0] actor_x[TABLE_SLOTS];
        logic signed [15:0] actor_y[TABLE_SLOTS];
        logic [14:0]        actor_reach[TABLE_SLOTS];
        bit                 loaded[TABLE_SLOTS];
        bit                 taken[TABLE_SLOTS];
        bit                 member[TABLE_SLOTS];
        vnaa_pkg::result_t  owed_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                actor_x[i] = '0;
                actor_y[i] = '0;
                actor_reach[i] = '0;
                loaded[i] = 1'b0;
                taken[i] = 1'b0;
                member[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_item(vnaa_pkg::action_t op, logic [3:0] s,
                                logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [15:0] hx, logic signed [15:0] hy,
                                logic [14:0] r);
            vnaa_pkg::result_t res;
            longint            dx, dy, sq_sum, best;
            bit                found;
            res = '0;
            res.item_kind = op;
            found = 1'b0;
            best = 0;
            case (op)
                vnaa_pkg::ACT_START:
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        loaded[i] = 1'b0;
                        taken[i] = 1'b0;
                        member[i] = 1'b0;
                    end
                end
                vnaa_pkg::ACT_LOAD:
                begin
                    if (int'(s) < TABLE_SLOTS)
                    begin
                        actor_x[s] = px;
                        actor_y[s] = py;
                        actor_reach[s] = r;
                        loaded[s] = 1'b1;
                        taken[s] = 1'b0;
                        member[s] = 1'b0;
                    end
                end
                vnaa_pkg::ACT_OPEN:
                begin
                    // first volume to contain an actor keeps it for the frame
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        member[i] = 1'b0;
                        if (loaded[i] && !taken[i] && actor_x[i] >= px && actor_x[i] <= hx
                            && actor_y[i] >= py && actor_y[i] <= hy)
                        begin
                            member[i] = 1'b1;
                            taken[i] = 1'b1;
                            res.members_added = res.members_added + 5'd1;
                        end
                    end
                end
                default:
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (member[i])
                        begin
                            dx = longint'(px) - longint'(actor_x[i]);
                            dy = longint'(py) - longint'(actor_y[i]);
                            sq_sum = dx * dx + dy * dy;
                            // strict compare keeps the lowest slot on a tie
                            if (!found || sq_sum < best)
                            begin
                                found = 1'b1;
                                best = sq_sum;
                                res.actor_index = 4'(i);
                            end
                        end
                    end
                    if (found)
                        res.voxel_kept = best < longint'(actor_reach[res.actor_index])
                                              * longint'(actor_reach[res.actor_index]);
                end
            endcase
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (member[i])
                    res.has_actor = 1'b1;
            owed_q = {owed_q, res};
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_result(vnaa_pkg::result_t got);
            vnaa_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d index %0d added %0d",
                                 got.item_kind, got.actor_index, got.members_added));
                return;
            end
            want = owed_q.pop_front();
            if (got.item_kind !== want.item_kind || got.has_actor !== want.has_actor
                || got.actor_index !== want.actor_index || got.voxel_kept !== want.voxel_kept
                || got.members_added !== want.members_added)
                report($sformatf({"kind %0d/%0d has_actor %0d/%0d index %0d/%0d ",
                                  "kept %0d/%0d added %0d/%0d (expected/actual)"},
                                 want.item_kind, got.item_kind, want.has_actor, got.has_actor,
                                 want.actor_index, got.actor_index, want.voxel_kept,
                                 got.voxel_kept, want.members_added, got.members_added));
        endfunction
    endclass

    assign_scoreboard sb;

    voxel_nearest_actor_assign_core #(
        .MAX_ACTORS(TABLE_SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .box_x_high   (box_x_high),
        .box_y_high   (box_y_high),
        .reach        (reach),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .item_kind    (item_kind),
        .has_actor    (has_actor),
        .actor_index  (actor_index),
        .voxel_kept   (voxel_kept),
        .members_added(members_added)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(vnaa_pkg::action_t op, logic [3:0] s, logic signed [15:0] px,
                             logic signed [15:0] py, logic signed [15:0] hx,
                             logic signed [15:0] hy, logic [14:0] r);
        bit accepted;
        accepted = 1'b0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        action = op;
        slot = s;
        pos_x = px;
        pos_y = py;
        box_x_high = hx;
        box_y_high = hy;
        reach = r;
        while (!accepted)
        begin
            @(posedge clk);
            if (!item_stall)
            begin
                accepted = 1'b1;
                sb.note_item(op, s, px, py, hx, hy, r);
            end
            @(negedge clk);
        end
        items_sent++;
    endtask

    function automatic logic signed [15:0] pick_coord(int span);
        if (span == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [14:0] pick_reach(int span);
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return '0;
        if (roll == 1 || span == 0)
            return 15'($urandom);
        return 15'($urandom_range(span));
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return C_MAX;
        if (v < -32768)
            return C_MIN;
        return 16'(v);
    endfunction

    task automatic open_volume(int span);
        int lx, ly, hx, hy, roll, width;
        roll = $urandom_range(9);
        width = (span == 0) ? 65535 : 2 * span;
        lx = int'(pick_coord(span));
        ly = int'(pick_coord(span));
        hx = lx + int'($urandom_range(width));
        hy = ly + int'($urandom_range(width));
        if (roll == 0)
        begin
            lx = -32768;
            ly = -32768;
            hx = 32767;
            hy = 32767;
        end
        else if (roll == 1)
            hx = lx - 1 - int'($urandom_range(16));
        else if (roll == 2)
            hy = ly - 1 - int'($urandom_range(16));
        send_item(vnaa_pkg::ACT_OPEN, 4'($urandom), clamp16(lx), clamp16(ly), clamp16(hx),
                  clamp16(hy), 15'($urandom));
    endtask

    task automatic send_noise();
        send_item(vnaa_pkg::action_t'($urandom_range(3)), 4'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
    endtask

    // One frame: usually a clear, then actor loads, then volumes each followed by voxels, sometimes noise
    task automatic random_frame();
        int                 span, k;
        logic signed [15:0] vx, vy;
        logic signed [15:0] seen_x[$];
        logic signed [15:0] seen_y[$];
        span = ($urandom_range(7) == 0) ? 0 : (1 << $urandom_range(5, 12));
        if ($urandom_range(7) != 0)
            send_item(vnaa_pkg::ACT_START, 4'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 15'($urandom));
        repeat ($urandom_range(1, TABLE_SLOTS))
        begin
            // shared positions give distance ties
            if (seen_x.size() != 0 && $urandom_range(5) == 0)
            begin
                k = $urandom_range(seen_x.size() - 1);
                vx = seen_x[k];
                vy = seen_y[k];
            end
            else
            begin
                vx = pick_coord(span);
                vy = pick_coord(span);
            end
            seen_x = {seen_x, vx};
            seen_y = {seen_y, vy};
            send_item(vnaa_pkg::ACT_LOAD, 4'($urandom), vx, vy, 16'($urandom), 16'($urandom),
                      pick_reach(span));
        end
        repeat ($urandom_range(1, 3))
        begin
            open_volume(span);
            repeat ($urandom_range(2, 8))
            begin
                if ($urandom_range(3) == 0)
                begin
                    k = $urandom_range(seen_x.size() - 1);
                    vx = seen_x[k] + 16'(int'($urandom_range(2)) - 1);
                    vy = seen_y[k] + 16'(int'($urandom_range(2)) - 1);
                end
                else
                begin
                    vx = pick_coord(span);
                    vy = pick_coord(span);
                end
                send_item(vnaa_pkg::ACT_CLASSIFY, 4'($urandom), vx, vy, 16'($urandom),
                          16'($urandom), 15'($urandom));
            end
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                send_noise();
    endtask

    task automatic run_directed();
        // empty table: no member for a voxel or a volume
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'hF, C_MAX, C_MIN, C_MAX, C_MIN, R_MAX);
        send_item(vnaa_pkg::ACT_OPEN, 4'h0, C_MIN, C_MIN, C_MAX, C_MAX, 15'h0);
        send_item(vnaa_pkg::ACT_LOAD, 4'h0, C_MIN, C_MIN, C_MAX, C_MAX, R_MAX);
        send_item(vnaa_pkg::ACT_LOAD, 4'hF, C_MAX, C_MAX, C_MIN, C_MIN, 15'h0);
        send_item(vnaa_pkg::ACT_LOAD, 4'h3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd1);
        send_item(vnaa_pkg::ACT_LOAD, 4'h5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd16);
        // inverted boxes hold nothing
        send_item(vnaa_pkg::ACT_OPEN, 4'hA, 16'sd16, 16'sd16, -16'sd16, -16'sd16, 15'h0);
        send_item(vnaa_pkg::ACT_OPEN, 4'h5, 16'sd0, C_MIN, -16'sd1, C_MAX, 15'h0);
        send_item(vnaa_pkg::ACT_OPEN, 4'h0, C_MIN, C_MIN, C_MAX, C_MAX, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, C_MIN, C_MIN, 16'sd0, 16'sd0, 15'h0);
        // zero reach keeps nothing, even at distance zero
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, C_MAX, C_MAX, 16'sd0, 16'sd0, 15'h0);
        // slots 3 and 5 tie; reach 1 keeps distance 0 but not 1
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, C_MAX, C_MIN, 16'sd0, 16'sd0, 15'h0);
        // actors already taken: another volume is empty
        send_item(vnaa_pkg::ACT_OPEN, 4'h0, C_MIN, C_MIN, C_MAX, C_MAX, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h0);
        // reload frees the slot; a one-point box is inclusive
        send_item(vnaa_pkg::ACT_LOAD, 4'h5, 16'sd16, 16'sd16, 16'sd0, 16'sd0, 15'h4000);
        send_item(vnaa_pkg::ACT_OPEN, 4'h0, 16'sd16, 16'sd16, 16'sd16, 16'sd16, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, C_MIN, C_MAX, 16'sd0, 16'sd0, 15'h0);
        send_item(vnaa_pkg::ACT_START, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h0);
        // corner to corner: widest squared distance
        send_item(vnaa_pkg::ACT_LOAD, 4'h7, C_MIN, C_MIN, 16'sd0, 16'sd0, R_MAX);
        send_item(vnaa_pkg::ACT_OPEN, 4'h0, C_MIN, C_MIN, C_MAX, C_MAX, 15'h0);
        send_item(vnaa_pkg::ACT_CLASSIFY, 4'h0, C_MAX, C_MAX, 16'sd0, 16'sd0, 15'h0);
        send_item(vnaa_pkg::ACT_START, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h0);
    endtask

    // Result side: random stall, plus a long hold-off on request
    initial
    begin : result_side
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            result_stall = !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : monitor
        vnaa_pkg::result_t got;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got.item_kind = item_kind;
                got.has_actor = has_actor;
                got.actor_index = actor_index;
                got.voxel_kept = voxel_kept;
                got.members_added = members_added;
                sb.check_result(got);
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_CYCLES)
                begin
                    $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit hold_issued;
        bit drain_issued;
        hold_issued = 1'b0;
        drain_issued = 1'b0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        while (items_sent < TOTAL_ITEMS)
        begin
            if (!hold_issued && items_sent >= 150)
            begin
                hold_issued = 1'b1;
                hold_request = 1'b1;
            end
            if (!drain_issued && items_sent >= 300)
            begin
                drain_issued = 1'b1;
                item_valid = 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            calm = (items_sent >= 330 && items_sent < 430);
            random_frame();
        end
        item_valid = 1'b0;
        calm = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
